/* rtl/core/map_delta_coordinate_decoder_unit_assert.svh */
// assertion macros for the map delta coordinate decoder
// used by the port checker; needs nothing else
`ifndef MAP_DELTA_COORDINATE_DECODER_UNIT_ASSERT_SVH
`define MAP_DELTA_COORDINATE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define MDCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdcd check failed");

// next-cycle implication, ignored while in reset
`define MDCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdcd check failed");

`endif

/* rtl/core/mdcd_pkg.sv */
// shared types and constants of the map delta coordinate decoder
// no dependencies
package mdcd_pkg;

    // token length limit, characters taken before a forced close
    localparam int TOKEN_LIMIT = 20;
    localparam int LEN_W       = $clog2(TOKEN_LIMIT + 2);

    // character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // queue depth between the parser and the accumulator
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // command from the parser to the accumulator
    typedef struct packed {
        logic        emit;   // a result is produced
        logic        brk;    // segment break
        logic        neg;    // delta is minus the magnitude
        logic [31:0] mag;    // delta magnitude
        logic        clr;    // clear sums and axis afterwards
    } cmd_t;

endpackage

/* rtl/core/mdcd_front.sv */
// character parser: classifies bytes, runs the token reader, issues commands
// depends on mdcd_pkg
module mdcd_front
    import mdcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] ch
    input  logic       s_tlast,    // end_of_text
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    typedef enum logic [1:0] {PH_SKIP, PH_NUM, PH_DONE} phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        minus;
        logic [31:0] mag;
    } tok_t;

    localparam tok_t TOK_CLEAR = '{phase: PH_SKIP, minus: 1'b0, mag: 32'd0};

    logic             open_reg, open_next;
    tok_t             tok_reg, tok_next;
    logic [LEN_W-1:0] len_reg, len_next;
    tok_t             fed;
    cmd_t             cmd;
    logic             accept;

    // one decimal step with saturation at all ones
    function automatic logic [31:0] take_digit(logic [31:0] mag, logic [7:0] c);
        logic [35:0] m;
        m = {4'd0, mag} * 36'd10 + {28'd0, c - CH_ZERO};
        return (m[35:32] != 4'd0) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    // atol-style reader, one character
    function automatic tok_t feed(tok_t t, logic [7:0] c);
        tok_t r;
        logic digit;
        r     = t;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (t.phase)
            PH_SKIP:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    r.phase = PH_SKIP;
                else if (c == CH_PLUS)
                    r.phase = PH_NUM;
                else if (c == CH_MINUS)
                begin
                    r.minus = 1'b1;
                    r.phase = PH_NUM;
                end
                else if (digit)
                begin
                    r.mag   = take_digit(t.mag, c);
                    r.phase = PH_NUM;
                end
                else
                    r.phase = PH_DONE;
            end
            PH_NUM:
            begin
                if (digit)
                    r.mag = take_digit(t.mag, c);
                else
                    r.phase = PH_DONE;
            end
            default: r = t;
        endcase
        return r;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // classify the byte and step the token
    always_comb
    begin
        fed       = feed(open_reg ? tok_reg : TOK_CLEAR, s_tdata);
        open_next = open_reg;
        tok_next  = tok_reg;
        len_next  = len_reg;
        cmd       = '{emit: 1'b0, brk: 1'b0, neg: 1'b0, mag: 32'd0, clr: s_tlast};
        if (open_reg)
        begin
            if (s_tdata == CH_COMMA || s_tdata == CH_COLON)
            begin
                cmd.emit  = 1'b1;
                cmd.mag   = tok_reg.mag;
                cmd.neg   = tok_reg.minus ^ (s_tdata == CH_COLON);
                open_next = 1'b0;
                tok_next  = TOK_CLEAR;
                len_next  = '0;
            end
            else
            begin
                tok_next = fed;
                len_next = len_reg + LEN_W'(1);
                if (len_next > LEN_W'(TOKEN_LIMIT))
                begin
                    cmd.emit  = 1'b1;
                    cmd.mag   = fed.mag;
                    cmd.neg   = fed.minus;
                    open_next = 1'b0;
                    tok_next  = TOK_CLEAR;
                    len_next  = '0;
                end
            end
        end
        else if (s_tdata == CH_HASH)
        begin
            cmd.emit = 1'b1;
            cmd.brk  = 1'b1;
        end
        else if (s_tdata >= CH_LO_A && s_tdata <= CH_LO_Z)
        begin
            cmd.emit = 1'b1;
            cmd.mag  = {24'd0, s_tdata - CH_LO_A};
        end
        else if (s_tdata >= CH_UP_A && s_tdata <= CH_UP_Z)
        begin
            cmd.emit = 1'b1;
            cmd.neg  = 1'b1;
            cmd.mag  = {24'd0, s_tdata - CH_UP_A};
        end
        else
        begin
            open_next = 1'b1;
            tok_next  = fed;
            len_next  = LEN_W'(1);
        end
        // end of text flushes an open token
        if (s_tlast)
        begin
            if (open_next)
            begin
                cmd.emit = 1'b1;
                cmd.mag  = tok_next.mag;
                cmd.neg  = tok_next.minus;
            end
            open_next = 1'b0;
            tok_next  = TOK_CLEAR;
            len_next  = '0;
        end
    end

    assign q_push = accept && (cmd.emit || s_tlast);
    assign q_cmd  = cmd;

    // token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            tok_reg  <= TOK_CLEAR;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            open_reg <= open_next;
            tok_reg  <= tok_next;
            len_reg  <= len_next;
        end
    end

endmodule

/* rtl/core/mdcd_queue.sv */
// small command queue between parser and accumulator
// depends on mdcd_pkg
module mdcd_queue
    import mdcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

/* rtl/core/mdcd_back.sv */
// accumulator: saturating sums, axis toggle, scale multiply, output register
// depends on mdcd_pkg
module mdcd_back
    import mdcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         q_empty,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [0] axis, [32:1] raw_sum, [96:33] coord
    output logic         m_tuser    // is_break
);

    localparam logic CFG_LON = 1'b0;
    localparam logic CFG_LAT = 1'b1;

    logic [31:0]        lon_scale_reg, lat_scale_reg;
    logic signed [31:0] lon_sum_reg, lat_sum_reg;
    logic               next_lat_reg;

    logic               s1_valid_reg, s1_brk_reg, s1_axis_reg;
    logic signed [31:0] s1_sum_reg;
    logic [31:0]        s1_scale_reg;

    logic               out_valid_reg, out_brk_reg, out_axis_reg;
    logic signed [31:0] out_sum_reg;
    logic signed [63:0] out_coord_reg;

    logic               out_en, s1_free;
    logic signed [31:0] delta, cur_sum, sum_next;
    logic signed [33:0] wide_sum;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] product;

    assign out_en  = !out_valid_reg || m_tready;
    assign s1_free = !s1_valid_reg || out_en;
    assign q_pop   = !q_empty && s1_free;

    // saturate the token value, then the sum
    always_comb
    begin
        if (q_cmd.neg)
            delta = (q_cmd.mag > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q_cmd.mag);
        else
            delta = (q_cmd.mag > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_cmd.mag);
        cur_sum  = next_lat_reg ? lat_sum_reg : lon_sum_reg;
        wide_sum = 34'(cur_sum) + 34'(delta);
        if (wide_sum[33:31] == 3'b000 || wide_sum[33:31] == 3'b111)
            sum_next = wide_sum[31:0];
        else
            sum_next = wide_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    // signed sum times unsigned scale
    assign mul_a   = {s1_sum_reg[31], s1_sum_reg};
    assign mul_b   = {1'b0, s1_scale_reg};
    assign product = mul_a * mul_b;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_scale_reg <= 32'd6425256;
            lat_scale_reg <= 32'd6425256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LON: lon_scale_reg <= cfg_data;
                CFG_LAT: lat_scale_reg <= cfg_data;
                default: lon_scale_reg <= lon_scale_reg;
            endcase
        end
    end

    // running sums and axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_sum_reg  <= '0;
            lat_sum_reg  <= '0;
            next_lat_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            if (q_cmd.brk || q_cmd.clr)
            begin
                lon_sum_reg  <= '0;
                lat_sum_reg  <= '0;
                next_lat_reg <= 1'b0;
            end
            else if (q_cmd.emit)
            begin
                if (next_lat_reg)
                    lat_sum_reg <= sum_next;
                else
                    lon_sum_reg <= sum_next;
                next_lat_reg <= !next_lat_reg;
            end
        end
    end

    // first stage: sum and scale held for the multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= q_pop && q_cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_brk_reg   <= q_cmd.brk;
            s1_axis_reg  <= q_cmd.brk ? 1'b0 : next_lat_reg;
            s1_sum_reg   <= q_cmd.brk ? 32'sd0 : sum_next;
            s1_scale_reg <= next_lat_reg ? lat_scale_reg : lon_scale_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            out_brk_reg   <= s1_brk_reg;
            out_axis_reg  <= s1_axis_reg;
            out_sum_reg   <= s1_sum_reg;
            out_coord_reg <= product[63:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_brk_reg;
    assign m_tdata  = {7'd0, out_coord_reg, out_sum_reg, out_axis_reg};

endmodule

/* rtl/core/map_delta_coordinate_decoder_unit.sv */
// map delta coordinate decoder, top level
// Input stream: one text character per request in s_tdata, s_tlast on the
// final character of a text. Output stream: one request per coordinate value
// or segment break; m_tuser marks a break, m_tdata carries axis, the running
// raw sum and the sum times the axis scale (signed Q32.32 radians).
// Config port: cfg_we with cfg_index 0 writes lon_scale, 1 writes lat_scale;
// write only while the block is idle.
// Throughput: one character per cycle while s_tready is high; the parser, the
// saturating add and the 33x33 multiply work on successive characters at once.
// A result passes from the parser into the queue, then through the sum stage
// and the multiply into the output register before it shows on m_tvalid.
// A four-entry command queue sits between the parser and the accumulator;
// when m_tready is low the output register holds, the queue fills, and
// s_tready falls once it is full. No results are dropped.
// Reset: sums, axis and token state clear, both scales return to 6425256,
// no results pending.
// depends on mdcd_pkg, mdcd_front, mdcd_queue, mdcd_back
module map_delta_coordinate_decoder_unit
    import mdcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] ch
    input  logic         s_tlast,    // end_of_text
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // [0] axis, [32:1] raw_sum, [96:33] coord
    output logic         m_tuser,    // is_break
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t push_cmd, pop_cmd;

    // parser
    mdcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // command queue
    mdcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // accumulator and multiplier
    mdcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/core/mdcd_checker.sv */
// port checker for the map delta coordinate decoder, bound to the top level
// depends on map_delta_coordinate_decoder_unit_assert.svh
`include "map_delta_coordinate_decoder_unit_assert.svh"

module mdcd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser
);

    // a stalled result request holds its payload
    `MDCD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a break carries zero axis, sum and coordinate
    `MDCD_ASSERT_NOW(a_break_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 104'd0)

    // a zero sum scales to a zero coordinate
    `MDCD_ASSERT_NOW(a_zero_coord, clk, rst_n, m_tvalid && m_tdata[32:1] == 32'd0, m_tdata[96:33] == 64'd0)

    // a negative coordinate comes only with a negative sum
    `MDCD_ASSERT_NOW(a_coord_sign, clk, rst_n, m_tvalid && m_tdata[96] == 1'b1, m_tdata[32] == 1'b1)

endmodule

bind map_delta_coordinate_decoder_unit mdcd_checker u_mdcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/map_delta_coordinate_checker.sv */
`timescale 1ns / 100ps
// checker for the map delta coordinate decoder: watches both streams and the scale port,
// predicts every coordinate and break request and compares them in order
// depends on mdcd_pkg
module map_delta_coordinate_checker
    import mdcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] ch
    input  logic         s_tlast,    // end_of_text
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,    // [0] axis, [32:1] raw_sum, [96:33] coord
    input  logic         m_tuser,    // is_break
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           open_count
);

    localparam logic [31:0] SCALE_RESET  = 32'd6425256;
    localparam int          REPORT_LIMIT = 10;
    localparam longint      SUM_MAX      = 64'sd2147483647;
    localparam longint      SUM_MIN      = -64'sd2147483648;

    typedef enum logic {AXIS_LON = 1'b0, AXIS_LAT = 1'b1} axis_e;
    typedef enum logic [1:0] {PH_SKIP_SPACE, PH_NUMBER, PH_ENDED} token_phase_e;

    typedef struct packed {
        logic        is_break;
        logic        axis;
        logic [31:0] raw_sum;
        logic [63:0] coord;
    } coord_result_t;

    // scales indexed by register index, which equals the axis code
    logic [31:0]   axis_scale [2];
    int            lon_sum;
    int            lat_sum;
    axis_e         next_axis;
    logic          tok_open;
    logic          tok_minus;
    token_phase_e  tok_phase;
    logic [31:0]   tok_mag;
    logic [4:0]    tok_len;
    coord_result_t coord_q[$];

    function automatic int sat32(longint v);
        if (v > SUM_MAX)
            return int'(SUM_MAX);
        if (v < SUM_MIN)
            return int'(SUM_MIN);
        return int'(v);
    endfunction

    function automatic void clear_token();
        tok_open  = 1'b0;
        tok_phase = PH_SKIP_SPACE;
        tok_minus = 1'b0;
        tok_mag   = '0;
        tok_len   = '0;
    endfunction

    function automatic void clear_sums();
        lon_sum   = 0;
        lat_sum   = 0;
        next_axis = AXIS_LON;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // one decimal step, magnitude saturates at all ones
    function automatic void take_digit(logic [7:0] c);
        logic [63:0] grown;
        grown   = {32'b0, tok_mag} * 64'd10 + {56'b0, 8'(c - CH_ZERO)};
        tok_mag = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    endfunction

    // number parsing: whitespace, optional sign, digits, stop at the first other byte
    function automatic void feed(logic [7:0] c);
        case (tok_phase)
            PH_SKIP_SPACE:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    return;
                if (c == CH_PLUS)
                    tok_phase = PH_NUMBER;
                else if (c == CH_MINUS)
                begin
                    tok_minus = 1'b1;
                    tok_phase = PH_NUMBER;
                end
                else if (is_digit(c))
                begin
                    take_digit(c);
                    tok_phase = PH_NUMBER;
                end
                else
                    tok_phase = PH_ENDED;
            end
            PH_NUMBER:
            begin
                if (is_digit(c))
                    take_digit(c);
                else
                    tok_phase = PH_ENDED;
            end
            default: ;
        endcase
    endfunction

    // add a delta to the current axis sum and queue the scaled coordinate
    function automatic void apply_delta(longint delta);
        coord_result_t r;
        int            s;
        longint        s_wide;
        longint        scale_wide;
        if (next_axis == AXIS_LAT)
        begin
            lat_sum = sat32(longint'(lat_sum) + delta);
            s       = lat_sum;
        end
        else
        begin
            lon_sum = sat32(longint'(lon_sum) + delta);
            s       = lon_sum;
        end
        s_wide     = s;
        scale_wide = {32'b0, axis_scale[next_axis]};
        r.is_break = 1'b0;
        r.axis     = next_axis;
        r.raw_sum  = s;
        r.coord    = s_wide * scale_wide;
        coord_q.insert(coord_q.size(), r);
        next_axis  = (next_axis == AXIS_LON) ? AXIS_LAT : AXIS_LON;
    endfunction

    function automatic void close_token(logic negate);
        longint v;
        v = {32'b0, tok_mag};
        if (tok_minus)
            v = -v;
        if (negate)
            v = -v;
        clear_token();
        apply_delta(sat32(v));
    endfunction

    // one accepted character
    function automatic void step_char(logic [7:0] c, logic eot);
        coord_result_t brk;
        longint        d;
        if (tok_open)
        begin
            if (c == CH_COMMA)
                close_token(1'b0);
            else if (c == CH_COLON)
                close_token(1'b1);
            else
            begin
                feed(c);
                tok_len++;
                if (tok_len > TOKEN_LIMIT)
                    close_token(1'b0);
            end
        end
        else if (c == CH_HASH)
        begin
            clear_sums();
            brk          = '0;
            brk.is_break = 1'b1;
            coord_q.insert(coord_q.size(), brk);
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = c - CH_LO_A;
            apply_delta(d);
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = c - CH_UP_A;
            apply_delta(-d);
        end
        else
        begin
            // any other byte opens a token, even a comma or a colon
            clear_token();
            tok_open = 1'b1;
            feed(c);
            tok_len = 1;
        end
        if (eot)
        begin
            if (tok_open)
                close_token(1'b0);
            clear_sums();
            clear_token();
        end
    endfunction

    function automatic void check_result(logic brk, logic ax, logic [31:0] sum,
                                         logic [63:0] coord);
        coord_result_t want;
        if (coord_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: result with nothing expected: brk=%0b axis=%0b sum=%0d coord=%0d",
                         $realtime, brk, ax, $signed(sum), $signed(coord));
            return;
        end
        want = coord_q.pop_front();
        if (want.is_break !== brk || want.axis !== ax || want.raw_sum !== sum ||
            want.coord !== coord)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("%0t: mismatch, expected brk=%0b axis=%0b sum=%0d coord=%0d",
                         $realtime, want.is_break, want.axis, $signed(want.raw_sum),
                         $signed(want.coord));
                $display("%0t:           actual   brk=%0b axis=%0b sum=%0d coord=%0d",
                         $realtime, brk, ax, $signed(sum), $signed(coord));
            end
        end
    endfunction

    // compare leaving requests, follow scale writes, predict from accepted characters
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_scale[0] = SCALE_RESET;
            axis_scale[1] = SCALE_RESET;
            clear_sums();
            clear_token();
            coord_q.delete();
            fail_count = 0;
            open_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata[0], m_tdata[32:1], m_tdata[96:33]);
            if (cfg_we)
                axis_scale[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                step_char(s_tdata, s_tlast);
            open_count = coord_q.size();
        end
    end

endmodule

/* test/tb_map_delta_coordinate_decoder_unit.sv */
`timescale 1ns / 100ps
// testbench top for the map delta coordinate decoder: drives characters and scale writes
// with random gaps and receiver stalls, the checker module does the comparing
// depends on mdcd_pkg, map_delta_coordinate_checker and the decoder rtl
module tb_map_delta_coordinate_decoder_unit;
    import mdcd_pkg::*;

    localparam logic REG_LON_SCALE = 1'b0;
    localparam logic REG_LAT_SCALE = 1'b1;
    localparam int   RESET_CYCLES  = 7;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   DRAIN_CYCLES  = 20;
    localparam int   DRAIN_LIMIT   = 20000;
    localparam int   HOLD_CYCLES   = 120;
    localparam int   PHASE_ITEMS   = 455;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // [7:0] ch
    logic         s_tlast;     // end_of_text
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;     // [0] axis, [32:1] raw_sum, [96:33] coord
    logic         m_tuser;     // is_break
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    int           fail_count;
    int           open_count;
    logic         hold_req;
    int           burst_left;
    logic         text_negative;
    logic [7:0]   word_chars[$];

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    map_delta_coordinate_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    map_delta_coordinate_checker coord_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // receiver: stretches of always ready, random and mostly stalled, plus one long hold-off
    initial
    begin : sink
        int stretch;
        int mode;
        m_tready = 1'b0;
        forever
        begin
            stretch = $urandom_range(8, 60);
            mode    = $urandom_range(0, 2);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one character request, sent in bursts with random gaps
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_string(string txt, logic last_at_end);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], last_at_end && i == txt.len() - 1);
    endtask

    // wait until every request is out and the pipeline has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_scales(logic [31:0] lon, logic [31:0] lat);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LON_SCALE;
        cfg_data  <= lon;
        @(negedge clk);
        cfg_index <= REG_LAT_SCALE;
        cfg_data  <= lat;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_space();
        return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    // append one character to the word being built
    function automatic void add_char(logic [7:0] c);
        word_chars.insert(word_chars.size(), c);
    endfunction

    // build one random word: letter, hash, number token, over-long token or noise
    task automatic make_word();
        int   kind;
        int   n;
        int   pick;
        logic long_num;
        logic biased;
        word_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 28)
            add_char(8'(CH_LO_A + $urandom_range(0, 25)));
        else if (kind < 42)
            add_char(8'(CH_UP_A + $urandom_range(0, 25)));
        else if (kind < 45)
            add_char(CH_HASH);
        else if (kind < 82)
        begin
            // number token, large ones lean to one sign per text so the sums saturate
            long_num = ($urandom_range(0, 6) == 0);
            biased   = long_num && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) add_char(rand_space());
            if (biased)
                add_char(text_negative ? CH_MINUS : CH_PLUS);
            else
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    add_char(CH_PLUS);
                else if (pick == 1)
                    add_char(CH_MINUS);
            end
            n = long_num ? $urandom_range(10, 11) : $urandom_range(0, 4);
            if (word_chars.size() == 0 && n == 0)
                n = 1;
            for (int i = 0; i < n; i++)
            begin
                if (long_num && i == 0)
                    add_char(8'(CH_ZERO + $urandom_range(1, 9)));
                else
                    add_char(rand_digit());
                if (!long_num && $urandom_range(0, 19) == 0)
                    add_char(8'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 9);
            if (biased || pick < 5)
                add_char(CH_COMMA);
            else if (pick < 9)
                add_char(CH_COLON);
        end
        else if (kind < 88)
        begin
            // token that runs into the length limit
            n = $urandom_range(TOKEN_LIMIT + 1, TOKEN_LIMIT + 4);
            for (int i = 0; i < n; i++)
                add_char(($urandom_range(0, 4) == 0 && i > 0) ? rand_space() : rand_digit());
        end
        else
        begin
            // noise over the full byte range
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                add_char(CH_COMMA);
        end
    endtask

    // one phase: new scales, then random words, ending on an end of text
    task automatic run_phase(logic [31:0] lon, logic [31:0] lat, logic with_hold);
        int   sent;
        logic last;
        wait_idle();
        write_scales(lon, lat);
        if (with_hold)
            hold_req = 1'b1;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            make_word();
            last = ($urandom_range(0, 49) == 0);
            foreach (word_chars[i])
            begin
                send_char(word_chars[i], last && i == word_chars.size() - 1);
                sent++;
            end
            if (last)
                text_negative = 1'($urandom_range(0, 1));
        end
        send_char(8'(CH_LO_A + $urandom_range(0, 25)), 1'b1);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int waited;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_LON_SCALE;
        cfg_data      = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        text_negative = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: break, letter extremes, double negation, empty token,
        // comma opening a token, digits fed to an ended token, end of text inside a token
        send_string("#aZzA", 1'b0);
        send_string("-12:", 1'b0);
        send_string("x,", 1'b0);
        send_string(":,", 1'b0);
        send_string("9999999999,", 1'b0);
        send_string("5", 1'b1);

        // random phases over extreme and random scales
        run_phase(32'd0, 32'hFFFF_FFFF, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd0, 1'b1);
        run_phase($urandom, $urandom, 1'b0);
        run_phase($urandom, 32'd1, 1'b0);

        s_tvalid <= 1'b0;
        waited = 0;
        while (open_count != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
